// ----- hdl/ist_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath bundles for the interpolation search table.
package ist_pkg;

  // Fixed field widths of the channels and the register
  localparam int ITEM_BITS  = 16;
  localparam int INDEX_BITS = 7;
  localparam int COUNT_BITS = 8;

  // Defaults for the top level parameters
  localparam int DEFAULT_TABLE_DEPTH = 128;
  localparam int DEFAULT_VALUE_BITS  = 16;

  // Operation codes of a request
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic write;      // store the request value in the table
    logic start;      // load key and open the full window
    logic rd_low;     // read entry at low
    logic rd_high;    // capture low entry, read entry at high
    logic cap_high;   // capture high entry
    logic probe_inc;  // count one probe
    logic probe_low;  // equal window ends: probe at low
    logic mul_load;   // multiply and load the divider
    logic div_step;   // one restoring division step
    logic probe_sum;  // probe = low + quotient
    logic rd_probe;   // read entry at probe
    logic narrow;     // record hit or shrink the window
    logic out_load;   // load the result register
  } ist_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic window_empty;
    logic in_range;
    logic ends_equal;
    logic div_last;
    logic probe_hit;
    logic out_free;
  } ist_stat_t;

endpackage

// ----- hdl/ist_if.sv -----
`timescale 1ns / 1ps
// Request and result channel interfaces of the interpolation search table.
interface ist_req_if;
  import ist_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [INDEX_BITS-1:0]        entry_index;
  logic signed [ITEM_BITS-1:0]  item_value;

  modport source (output valid, operation, entry_index, item_value, input ready);
  modport sink   (input valid, operation, entry_index, item_value, output ready);
endinterface

interface ist_rsp_if;
  import ist_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [INDEX_BITS-1:0]  position;
  logic [COUNT_BITS-1:0]  probe_count;

  modport source (output valid, found, position, probe_count, input ready);
  modport sink   (input valid, found, position, probe_count, output ready);
endinterface

// ----- hdl/ist_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: table memory, search window, multiplier, serial divider and result register.
module ist_datapath #(
  parameter int TABLE_DEPTH = ist_pkg::DEFAULT_TABLE_DEPTH,
  parameter int VALUE_BITS  = ist_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ist_pkg::COUNT_BITS-1:0]      cfg_data,
  input  logic [ist_pkg::INDEX_BITS-1:0]      entry_index,
  input  logic signed [ist_pkg::ITEM_BITS-1:0] item_value,
  input  ist_pkg::ist_cmd_t                   cmd,
  output ist_pkg::ist_stat_t                  stat,
  ist_rsp_if.source                           rsp
);
  import ist_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int IW  = AW + 2;
  localparam int KW  = (VALUE_BITS > ITEM_BITS) ? VALUE_BITS : ITEM_BITS;
  localparam int PW  = KW + AW + 1;
  localparam int DCW = $clog2(AW + 1);

  // Table storage
  logic [VALUE_BITS-1:0]        mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0]        rd_data;
  logic signed [VALUE_BITS-1:0] rd_sval;
  logic signed [KW-1:0]         entry;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [31:0]                  idx_ext;
  logic signed [KW-1:0]         item_ext;

  // Search state
  logic [CW-1:0]                count;
  logic [31:0]                  cfg_ext;
  logic signed [KW-1:0]         key;
  logic signed [KW-1:0]         tl;
  logic signed [KW-1:0]         th;
  logic signed [IW-1:0]         low;
  logic signed [IW-1:0]         high;
  logic signed [IW-1:0]         probe;
  logic signed [IW-1:0]         span;
  logic [COUNT_BITS-1:0]        probes;
  logic                         hit;

  // Arithmetic
  logic signed [KW:0]           num_diff;
  logic signed [KW:0]           den_diff;
  logic [KW-1:0]                mul_a;
  logic [AW-1:0]                mul_b;
  logic [KW+AW-1:0]             product;
  logic [KW-1:0]                divisor;
  logic [PW-1:0]                pair;
  logic [PW-1:0]                pair_sh;
  logic [PW-1:0]                pair_next;
  logic [KW:0]                  upper;
  logic [DCW-1:0]               div_cnt;

  // Result register
  logic                         out_valid;
  logic                         found;
  logic [INDEX_BITS-1:0]        position;
  logic [COUNT_BITS-1:0]        probe_count;
  logic [31:0]                  probe_ext;

  // Value and index conversion
  assign item_ext = KW'(item_value);
  assign idx_ext  = 32'(entry_index);
  assign wr_addr  = idx_ext[AW-1:0];
  assign wr_en    = cmd.write && (idx_ext < TABLE_DEPTH);
  assign rd_sval  = rd_data;
  assign entry    = KW'(rd_sval);

  // Read address select
  always_comb begin
    rd_en   = cmd.rd_low || cmd.rd_high || cmd.rd_probe;
    rd_addr = probe[AW-1:0];
    if (cmd.rd_low) begin
      rd_addr = low[AW-1:0];
    end else if (cmd.rd_high) begin
      rd_addr = high[AW-1:0];
    end
  end

  // Table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_ext[VALUE_BITS-1:0];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Entry count register, saturating to the depth
  assign cfg_ext = 32'(cfg_data);
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_we) begin
      count <= (cfg_ext > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(cfg_ext);
    end
  end

  // Interpolation terms
  assign num_diff = (KW+1)'(key) - (KW+1)'(tl);
  assign den_diff = (KW+1)'(th) - (KW+1)'(tl);
  assign span     = high - low;
  assign mul_a    = num_diff[KW-1:0];
  assign mul_b    = span[AW-1:0];
  assign product  = mul_a * mul_b;

  // Restoring division step: one quotient bit per cycle
  always_comb begin
    pair_sh   = {pair[PW-2:0], 1'b0};
    upper     = pair_sh[PW-1:AW];
    pair_next = pair_sh;
    if (upper >= {1'b0, divisor}) begin
      pair_next[PW-1:AW] = upper - {1'b0, divisor};
      pair_next[0]       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      pair    <= {1'b0, product};
      divisor <= den_diff[KW-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      pair    <= pair_next;
      div_cnt <= div_cnt + DCW'(1);
    end
  end

  // Window and probe registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key    <= item_ext;
      low    <= '0;
      high   <= $signed(IW'(count)) - IW'(1);
      probes <= '0;
      hit    <= 1'b0;
    end
    if (cmd.rd_high) begin
      tl <= entry;
    end
    if (cmd.cap_high) begin
      th <= entry;
    end
    if (cmd.probe_inc && (probes != {COUNT_BITS{1'b1}})) begin
      probes <= probes + COUNT_BITS'(1);
    end
    if (cmd.probe_low) begin
      probe <= low;
    end
    if (cmd.probe_sum) begin
      probe <= low + $signed(IW'(pair[AW-1:0]));
    end
    if (cmd.narrow) begin
      if (entry == key) begin
        hit <= 1'b1;
      end else if (entry < key) begin
        low <= probe + IW'(1);
      end else begin
        high <= probe - IW'(1);
      end
    end
  end

  // Status to the controller
  assign stat.window_empty = low > high;
  assign stat.in_range     = (key >= tl) && (key <= th);
  assign stat.ends_equal   = th == tl;
  assign stat.div_last     = div_cnt == DCW'(AW - 1);
  assign stat.probe_hit    = entry == key;
  assign stat.out_free     = !out_valid || rsp.ready;

  // Result register, held while the receiver stalls
  assign probe_ext = 32'(probe[AW-1:0]);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= hit;
      position    <= hit ? probe_ext[INDEX_BITS-1:0] : '0;
      probe_count <= probes;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = found;
  assign rsp.position    = position;
  assign rsp.probe_count = probe_count;

endmodule

// ----- hdl/ist_controller.sv -----
`timescale 1ns / 1ps
// Controller: sequences the reads, probe arithmetic and result hand-off of one search.
module ist_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_operation,
  output logic                req_ready,
  output ist_pkg::ist_cmd_t   cmd,
  input  ist_pkg::ist_stat_t  stat
);
  import ist_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_WLOW  = 4'd2;
  localparam logic [3:0] S_WHIGH = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_PSUM  = 4'd7;
  localparam logic [3:0] S_PADDR = 4'd8;
  localparam logic [3:0] S_PCMP  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_operation == OP_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (stat.window_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_low = 1'b1;
          state_next = S_WLOW;
        end
      end
      S_WLOW: begin
        cmd.rd_high = 1'b1;
        state_next  = S_WHIGH;
      end
      S_WHIGH: begin
        cmd.cap_high = 1'b1;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.in_range) begin
          state_next = S_DONE;
        end else begin
          cmd.probe_inc = 1'b1;
          if (stat.ends_equal) begin
            cmd.probe_low = 1'b1;
            state_next    = S_PADDR;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_PSUM;
        end
      end
      S_PSUM: begin
        cmd.probe_sum = 1'b1;
        state_next    = S_PADDR;
      end
      S_PADDR: begin
        cmd.rd_probe = 1'b1;
        state_next   = S_PCMP;
      end
      S_PCMP: begin
        cmd.narrow = 1'b1;
        state_next = stat.probe_hit ? S_DONE : S_CHECK;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/interpolation_search_table_unit.sv -----
`timescale 1ns / 1ps
// Interpolation search table: top level joining controller and datapath.
//
// Requests arrive on req (valid/ready). A write request (operation 0) stores
// item_value at entry_index and gives no result. A search
// request (operation 1) runs interpolation search over the first entry_count
// entries and returns one result on rsp: found, position and probe_count.
// entry_count is set through cfg_we/cfg_data; the user must set it only while
// the block is idle, which the block itself does not enforce. One request is
// worked on at a time; req.ready is high only when idle. Each probe makes three
// table reads on the single memory port. A probe whose window ends differ also
// runs the serial divider, which yields one quotient bit a cycle; a probe whose
// window ends are equal skips the divider and probes at low.
// The result sits in an output register; while the receiver stalls it holds,
// and write requests are still taken. A finished search waits for the
// register to free before the block returns to idle.
// Reset clears the controller, the result valid flag and entry_count; table
// contents are undefined until written.
module interpolation_search_table_unit #(
  parameter int TABLE_DEPTH = ist_pkg::DEFAULT_TABLE_DEPTH,
  parameter int VALUE_BITS  = ist_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ist_pkg::COUNT_BITS-1:0]  cfg_data,
  ist_req_if.sink                         req,
  ist_rsp_if.source                       rsp
);
  import ist_pkg::*;

  ist_cmd_t  cmd;
  ist_stat_t stat;

  // Sequencer
  ist_controller u_ctl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_operation (req.operation),
    .req_ready     (req.ready),
    .cmd           (cmd),
    .stat          (stat)
  );

  // Table, arithmetic and result register
  ist_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .entry_index (req.entry_index),
    .item_value  (req.item_value),
    .cmd         (cmd),
    .stat        (stat),
    .rsp         (rsp)
  );

endmodule

// ----- tb/sv/search_result_checker.sv -----
`timescale 1ns / 1ps
// Checker for the search table: mirrors the table, predicts each search result, compares.
module search_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ist_pkg::COUNT_BITS-1:0] cfg_data,
  ist_req_if                             req,
  ist_rsp_if                             rsp,
  output int                             fail_count,
  output int                             pending
);
  import ist_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] position;
    logic [COUNT_BITS-1:0] probe_count;
  } lookup_t;

  lookup_t                     expected_lookups[$];
  logic signed [ITEM_BITS-1:0] mirror_table[DEPTH];
  int                          active_entries = 0;
  int                          mismatches = 0;

  // Interpolation search over the mirrored table
  function automatic lookup_t predict_lookup(input int key);
    lookup_t res;
    int      lo;
    int      hi;
    int      tl;
    int      th;
    int      pv;
    int      probe;
    int      probes;
    bit      hit;
    lo     = 0;
    hi     = active_entries - 1;
    probe  = 0;
    probes = 0;
    hit    = 1'b0;
    while (lo <= hi) begin
      tl = int'(mirror_table[lo]);
      th = int'(mirror_table[hi]);
      // key outside the window ends the search
      if (key < tl || key > th) break;
      probes++;
      // equal ends: no division, probe at low
      if (th == tl) probe = lo;
      else probe = lo + ((key - tl) * (hi - lo)) / (th - tl);
      pv = int'(mirror_table[probe]);
      if (pv == key) begin
        hit = 1'b1;
        break;
      end else if (pv < key) begin
        lo = probe + 1;
      end else begin
        hi = probe - 1;
      end
    end
    res.found       = hit;
    res.position    = hit ? probe[INDEX_BITS-1:0] : '0;
    res.probe_count = (probes > 255) ? 8'd255 : probes[COUNT_BITS-1:0];
    return res;
  endfunction

  // Track config and requests, check each result against the oldest prediction
  always @(posedge clk) begin : monitor
    lookup_t got;
    lookup_t want;
    if (rst) begin
      active_entries = 0;
      expected_lookups.delete();
    end else begin
      if (cfg_we) active_entries = (cfg_data > DEPTH) ? DEPTH : int'(cfg_data);
      if (rsp.valid && rsp.ready) begin
        got.found       = rsp.found;
        got.position    = rsp.position;
        got.probe_count = rsp.probe_count;
        if (expected_lookups.size() == 0) begin
          mismatches++;
          $error("result with no search pending: found %0d position %0d probe_count %0d",
                 got.found, got.position, got.probe_count);
        end else begin
          want = expected_lookups.pop_front();
          if (got.found !== want.found) begin
            mismatches++;
            $error("found: expected %0d, actual %0d", want.found, got.found);
          end
          if (got.position !== want.position) begin
            mismatches++;
            $error("position: expected %0d, actual %0d", want.position, got.position);
          end
          if (got.probe_count !== want.probe_count) begin
            mismatches++;
            $error("probe_count: expected %0d, actual %0d", want.probe_count,
                   got.probe_count);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.operation == OP_WRITE) mirror_table[req.entry_index] = req.item_value;
        else expected_lookups.push_back(predict_lookup(int'(req.item_value)));
      end
    end
    fail_count <= mismatches;
    pending    <= expected_lookups.size();
  end

endmodule

// ----- tb/sv/interpolation_search_table_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives table writes, searches and entry_count, and reports the verdict.
module interpolation_search_table_unit_tb;
  import ist_pkg::*;

  localparam int TABLE_SIZE  = DEFAULT_TABLE_DEPTH;
  localparam int ITEM_TARGET = 1650;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 600;
  localparam int VALUE_MIN   = -32768;
  localparam int VALUE_MAX   = 32767;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [COUNT_BITS-1:0]       cfg_data;
  logic                        hold_armed = 1'b0;
  int                          fail_count;
  int                          pending;
  int                          sent_count = 0;
  int                          burst_left = 1;
  int                          idle_cycles = 0;
  int                          shadow_vals[TABLE_SIZE];

  ist_req_if req_ch();
  ist_rsp_if rsp_ch();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interpolation_search_table_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  search_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one request and hold it until taken; bursts end in a random gap
  task automatic issue(input logic op, input int idx, input int val);
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.entry_index <= idx[INDEX_BITS-1:0];
    req_ch.item_value  <= val[ITEM_BITS-1:0];
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
    end
  endtask

  // Stop offering and wait until every search result is back, then let writes settle
  task automatic drain_block();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic set_entry_count(input int count);
    drain_block();
    cfg_we   <= 1'b1;
    cfg_data <= count[COUNT_BITS-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Stall watchdog: any accepted request or result restarts the count
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: stall patterns, plus one long hold-off when armed
  initial begin : result_sink
    int mode;
    int span;
    bit hold_done;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 60);
        repeat (span) begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Request side: directed cases, then phases of table fill and searches
  initial begin : request_source
    int cfg_val;
    int n;
    int m;
    int k;
    int style;
    int pick;
    int slot;
    int pos;
    int v;
    int step;
    int phase_no;
    bit descending;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= OP_WRITE;
    req_ch.entry_index <= '0;
    req_ch.item_value  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table after reset
    issue(OP_SEARCH, 0, 0);
    issue(OP_WRITE, TABLE_SIZE - 1, VALUE_MAX);
    issue(OP_WRITE, 0, VALUE_MIN);
    // single entry: hit, and key above the window
    set_entry_count(1);
    issue(OP_SEARCH, TABLE_SIZE - 1, VALUE_MIN);
    issue(OP_SEARCH, 0, VALUE_MAX);
    issue(OP_WRITE, 1, VALUE_MAX);
    // two entries spanning the full value range
    set_entry_count(2);
    issue(OP_SEARCH, 0, VALUE_MAX);
    issue(OP_SEARCH, 0, 0);
    issue(OP_SEARCH, 0, VALUE_MIN);
    issue(OP_SEARCH, 0, -1);
    // equal window ends
    issue(OP_WRITE, 1, VALUE_MIN);
    issue(OP_SEARCH, 0, VALUE_MIN);
    issue(OP_SEARCH, 0, 100);
    // table out of order
    issue(OP_WRITE, 0, 5);
    issue(OP_SEARCH, 0, 5);
    issue(OP_SEARCH, 0, VALUE_MIN);

    phase_no = 0;
    while (sent_count < ITEM_TARGET) begin
      case (phase_no)
        0: cfg_val = TABLE_SIZE;
        1: cfg_val = 255;           // saturates to the table depth
        2: cfg_val = 0;
        3: cfg_val = 8;             // long receiver hold-off phase
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 4)       cfg_val = 0;
          else if (pick < 12) cfg_val = $urandom_range(1, 2);
          else if (pick < 80) cfg_val = $urandom_range(3, 16);
          else if (pick < 95) cfg_val = $urandom_range(17, 64);
          else                cfg_val = $urandom_range(65, TABLE_SIZE);
        end
      endcase
      set_entry_count(cfg_val);
      if (phase_no == 3) hold_armed <= 1'b1;
      n = (cfg_val > TABLE_SIZE) ? TABLE_SIZE : cfg_val;

      // ascending table with a random shape
      style = $urandom_range(0, 4);
      if (style == 4) v = VALUE_MIN + int'($urandom_range(0, 200));
      else v = int'($urandom_range(0, 65535)) + VALUE_MIN;
      for (slot = 0; slot < n; slot++) begin
        shadow_vals[slot] = v;
        case (style)
          0:       step = $urandom_range(1, 600);
          1:       step = $urandom_range(0, 2);
          2:       step = 0;
          3:       step = $urandom_range(0, 65535 / (n + 1));
          default: step = slot * slot * int'($urandom_range(1, 4));
        endcase
        v = v + step;
        if (v > VALUE_MAX) v = VALUE_MAX;
      end
      descending = ($urandom_range(0, 1) == 1);
      for (slot = 0; slot < n; slot++) begin
        pos = descending ? (n - 1 - slot) : slot;
        issue(OP_WRITE, pos, shadow_vals[pos]);
      end

      // searches: mostly table keys and near misses, some noise
      m = (phase_no == 3) ? 20 : $urandom_range(4, 20);
      for (k = 0; k < m; k++) begin
        pick = $urandom_range(0, 99);
        if (n > 0 && pick < 55) begin
          issue(OP_SEARCH, $urandom_range(0, 127), shadow_vals[$urandom_range(0, n - 1)]);
        end else if (n > 0 && pick < 75) begin
          v = shadow_vals[$urandom_range(0, n - 1)];
          v = ($urandom_range(0, 1) == 1) ? v + 1 : v - 1;
          if (v > VALUE_MAX) v = VALUE_MAX;
          if (v < VALUE_MIN) v = VALUE_MIN;
          issue(OP_SEARCH, $urandom_range(0, 127), v);
        end else if (pick < 85) begin
          issue(OP_SEARCH, $urandom_range(0, 127), $urandom_range(0, 65535));
        end else if (pick < 92) begin
          issue(OP_SEARCH, $urandom_range(0, 127),
                ($urandom_range(0, 1) == 1) ? VALUE_MAX : VALUE_MIN);
        end else begin
          // stray write; inside the window it breaks the ordering
          slot = $urandom_range(0, TABLE_SIZE - 1);
          v = int'($urandom_range(0, 65535)) + VALUE_MIN;
          shadow_vals[slot] = v;
          issue(OP_WRITE, slot, v);
        end
      end
      phase_no++;
    end

    // drain and give the verdict
    drain_block();
    repeat (32) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
